@@ rtl/bdq_pkg.sv @@
// Shared types and constants for the bounded deque core.
// No dependencies; imported by every module of the block except bdq_ram.
package bdq_pkg;

   localparam int DEPTH  = 64;
   localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int OCC_W  = 7;
   localparam int DATA_W = 32;

   typedef logic [IDX_W-1:0] idx_type;
   typedef logic [OCC_W-1:0] occ_type;

   typedef enum logic [2:0] {
      MODE_PUSH_FRONT = 3'd0,
      MODE_PUSH_BACK  = 3'd1,
      MODE_POP_FRONT  = 3'd2,
      MODE_POP_BACK   = 3'd3,
      MODE_CLEAR      = 3'd4,
      MODE_CREATE     = 3'd5,
      MODE_DUMP       = 3'd6
   } mode_type;

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_UNDER = 2'd1,
      STATUS_OVER  = 2'd2
   } status_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] data;
      status_type               status;
      occ_type                  occupancy;
      logic                     last;
   } rsp_type;

   // (base + off) mod DEPTH, with off < DEPTH so one compare-subtract does
   function automatic idx_type wrap_add(idx_type base, occ_type off);
      logic [OCC_W:0] sum;
      sum = {{(OCC_W+1-IDX_W){1'b0}}, base} + {1'b0, off};
      if (sum >= (OCC_W+1)'(DEPTH))
         sum = sum - (OCC_W+1)'(DEPTH);
      return sum[IDX_W-1:0];
   endfunction

endpackage

@@ rtl/bdq_ram.sv @@
// Generic single-write, single-read synchronous RAM with a registered read port.
// Read data holds while no read is issued. No package dependencies.
module bdq_ram #(
   parameter int ADDR_W = 6,
   parameter int DATA_W = 32
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem [2**ADDR_W];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/bdq_out.sv @@
// Result output register: holds one result word until the sink takes it.
// Depends on bdq_pkg for the result word type.
module bdq_out (
   input  logic             clock,
   input  logic             reset,
   input  logic             load,
   input  bdq_pkg::rsp_type word,
   output logic             free,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [39:0]      rsp_tdata,   // data[31:0], occupancy[38:32], zero pad
   output logic [1:0]       rsp_tuser,   // status[1:0]
   output logic             rsp_tlast
);
   import bdq_pkg::*;

   logic    valid_ff;
   logic    valid_in;
   rsp_type word_ff;

   assign free     = !valid_ff || rsp_tready;
   assign valid_in = load || (valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (load) begin
         word_ff <= word;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {1'b0, word_ff.occupancy, word_ff.data};
   assign rsp_tuser  = word_ff.status;
   assign rsp_tlast  = word_ff.last;

endmodule

@@ rtl/bounded_double_ended_queue_core.sv @@
// Bounded deque over a ring RAM: command decode, pointer state, dump walk.
// Depends on bdq_pkg, bdq_ram and bdq_out.
//
//  port group | dir | carries
//  req_*      | in  | tuser = mode, tdata = value
//  rsp_*      | out | tdata = data + occupancy, tuser = status, tlast = last
//
// Push, clear, create, failed pop and unused modes: result loaded on accept.
// Pop: the result comes through a RAM read. Dump of n elements: one element
// per cycle from the RAM read port after the first read, while rsp is taken.
// Reset clears state, front index, count and walk; ptr and the ring RAM are not.
// A stalled result holds req_tready low; the walk pauses on the RAM read.
module bounded_double_ended_queue_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // value[31:0]
   input  logic [2:0]  req_tuser,   // mode[2:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // data[31:0], occupancy[38:32], zero pad
   output logic [1:0]  rsp_tuser,   // status[1:0]
   output logic        rsp_tlast
);
   import bdq_pkg::*;

   typedef enum logic {
      ST_IDLE,
      ST_READ
   } state_type;

   state_type state_ff, state_in;
   idx_type   front_ff, front_in;
   occ_type   count_ff, count_in;
   idx_type   ptr_ff, ptr_in;
   occ_type   walk_ff, walk_in;

   logic              accept;
   logic              out_free;
   logic              out_load;
   rsp_type           out_word;
   logic              wr_en;
   idx_type           wr_addr;
   logic [DATA_W-1:0] wr_data;
   logic              rd_en;
   idx_type           rd_addr;
   logic [DATA_W-1:0] rd_data;
   logic              full;
   logic              empty;

   assign full       = count_ff >= OCC_W'(DEPTH);
   assign empty      = count_ff == '0;
   assign req_tready = (state_ff == ST_IDLE) && out_free;
   assign accept     = req_tvalid && req_tready;
   assign wr_data    = req_tdata;

   always_comb begin
      state_in = state_ff;
      front_in = front_ff;
      count_in = count_ff;
      ptr_in   = ptr_ff;
      walk_in  = walk_ff;
      wr_en    = 1'b0;
      wr_addr  = front_ff;
      rd_en    = 1'b0;
      rd_addr  = front_ff;
      out_load = 1'b0;
      out_word.data      = '0;
      out_word.status    = STATUS_OK;
      out_word.occupancy = count_ff;
      out_word.last      = 1'b1;

      if (state_ff == ST_READ) begin
         if (out_free) begin
            out_load      = 1'b1;
            out_word.data = rd_data;
            out_word.last = walk_ff == OCC_W'(1);
            if (walk_ff == OCC_W'(1)) begin
               state_in = ST_IDLE;
            end else begin
               rd_en   = 1'b1;
               rd_addr = ptr_ff;
               ptr_in  = wrap_add(ptr_ff, OCC_W'(1));
            end
            walk_in = walk_ff - OCC_W'(1);
         end
      end else if (accept) begin
         case (req_tuser)
            MODE_PUSH_FRONT, MODE_PUSH_BACK: begin
               out_load = 1'b1;
               if (full) begin
                  out_word.status = STATUS_OVER;
               end else begin
                  wr_en = 1'b1;
                  if (req_tuser == MODE_PUSH_FRONT) begin
                     front_in = wrap_add(front_ff, OCC_W'(DEPTH - 1));
                     wr_addr  = front_in;
                  end else begin
                     wr_addr  = wrap_add(front_ff, count_ff);
                  end
                  count_in           = count_ff + OCC_W'(1);
                  out_word.occupancy = count_in;
               end
            end
            MODE_POP_FRONT, MODE_POP_BACK: begin
               if (empty) begin
                  out_load        = 1'b1;
                  out_word.status = STATUS_UNDER;
               end else begin
                  rd_en    = 1'b1;
                  count_in = count_ff - OCC_W'(1);
                  if (req_tuser == MODE_POP_FRONT) begin
                     front_in = wrap_add(front_ff, OCC_W'(1));
                  end else begin
                     rd_addr  = wrap_add(front_ff, count_in);
                  end
                  walk_in  = OCC_W'(1);
                  state_in = ST_READ;
               end
            end
            MODE_CLEAR: begin
               out_load           = 1'b1;
               front_in           = '0;
               count_in           = '0;
               out_word.occupancy = '0;
            end
            MODE_CREATE: begin
               out_load           = 1'b1;
               wr_en              = 1'b1;
               wr_addr            = '0;
               front_in           = '0;
               count_in           = OCC_W'(1);
               out_word.occupancy = count_in;
            end
            MODE_DUMP: begin
               if (empty) begin
                  out_load = 1'b1;
               end else begin
                  rd_en    = 1'b1;
                  ptr_in   = wrap_add(front_ff, OCC_W'(1));
                  walk_in  = count_ff;
                  state_in = ST_READ;
               end
            end
            default: begin
               out_load = 1'b1;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         front_ff <= '0;
         count_ff <= '0;
         walk_ff  <= '0;
      end else begin
         state_ff <= state_in;
         front_ff <= front_in;
         count_ff <= count_in;
         walk_ff  <= walk_in;
      end
      ptr_ff <= ptr_in;
   end

   // Each accepted word either writes or reads the RAM, never both, and the
   // next word is accepted at a later edge, so a write always lands before
   // any read of the same entry: no forwarding needed.
   bdq_ram #(
      .ADDR_W (IDX_W),
      .DATA_W (DATA_W)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   bdq_out u_out (
      .clock      (clock),
      .reset      (reset),
      .load       (out_load),
      .word       (out_word),
      .free       (out_free),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= OCC_W'(DEPTH))
      else $error("element count above depth");

   a_walk_live: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_READ |-> walk_ff != '0)
      else $error("read walk with nothing left");

   a_load_free: assert property (@(posedge clock) disable iff (reset)
      out_load |-> out_free)
      else $error("result overwritten before taken");

   a_push_count: assert property (@(posedge clock) disable iff (reset)
      accept && !full && (req_tuser == MODE_PUSH_FRONT || req_tuser == MODE_PUSH_BACK)
      |=> count_ff == $past(count_ff) + OCC_W'(1))
      else $error("push did not grow the count");
`endif

endmodule

@@ tb/tb.sv @@
// Self-checking testbench for bounded_double_ended_queue_core: random and directed deque
// commands, a built-in deque predictor, and word-by-word checking of the response stream.
// Depends on bdq_pkg and the bounded_double_ended_queue_core RTL.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import bdq_pkg::*;

   localparam int CLK_HALF   = 4;
   localparam int GAP_MAX    = 12;
   localparam int CMD_TARGET = 370;
   localparam int TAIL_WAIT  = 16;
   localparam int CYCLE_CAP  = 1_500_000;
   localparam int SHOW_MAX   = 10;
   // mode code with no operation behind it
   localparam logic [2:0] MODE_UNUSED = 3'd7;

   typedef struct {
      logic [2:0]  mode;
      logic [31:0] value;
      bit          hold;   // wait for all responses before sending
   } deque_cmd_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;    // value[31:0]
   logic [2:0]  req_tuser = '0;    // mode[2:0]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;         // data[31:0], occupancy[38:32], zero pad
   logic [1:0]  rsp_tuser;         // status[1:0]
   logic        rsp_tlast;

   deque_cmd_type pending_cmds[$];
   rsp_type       expected_words[$];

   // predictor state
   logic [31:0] ring_mirror [0:DEPTH-1];
   idx_type     mirror_front = '0;
   occ_type     mirror_count = '0;

   int  plan_count  = 0;   // occupancy as seen by the stimulus generator
   int  cmds_queued = 0;
   int  mismatches  = 0;
   int  cycle_count = 0;
   int  send_gap    = 0;
   int  send_burst  = 0;
   int  recv_stall  = 0;
   int  recv_burst  = 0;
   bit  req_taken   = 1'b0;
   bit  rsp_taken   = 1'b0;

   bounded_double_ended_queue_core u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #(CLK_HALF) clock = 1'b1;
      #(CLK_HALF) clock = 1'b0;
   end

   // idle cycles before the next word; occasional runs with no idling at all
   function automatic int draw_gap(inout int burst);
      if (burst > 0) begin
         burst--;
         return 0;
      end
      if ($urandom_range(0, 15) == 0)
         burst = $urandom_range(10, 40);
      return $urandom_range(0, GAP_MAX);
   endfunction

   function automatic logic [31:0] rand_word();
      case ($urandom_range(0, 7))
         0: return 32'h8000_0000;
         1: return 32'h7FFF_FFFF;
         2: return 32'h0000_0000;
         3: return 32'hFFFF_FFFF;
         default: return $urandom;
      endcase
   endfunction

   task automatic queue_cmd(input logic [2:0] mode, input logic [31:0] value, input bit hold);
      deque_cmd_type c;
      c.mode  = mode;
      c.value = value;
      c.hold  = hold;
      pending_cmds.push_back(c);
      cmds_queued++;
      case (mode)
         MODE_PUSH_FRONT, MODE_PUSH_BACK: if (plan_count < DEPTH) plan_count++;
         MODE_POP_FRONT, MODE_POP_BACK:   if (plan_count > 0) plan_count--;
         MODE_CLEAR:                      plan_count = 0;
         MODE_CREATE:                     plan_count = 1;
         default: ;
      endcase
   endtask

   // deque behavior: updates the mirror and queues the response words
   task automatic deque_apply(input logic [2:0] mode, input logic [31:0] value);
      rsp_type w;
      int      slot;
      int      k;
      w.data   = '0;
      w.status = STATUS_OK;
      w.last   = 1'b1;
      if (mode == MODE_DUMP && mirror_count != 0) begin
         for (k = 0; k < int'(mirror_count); k++) begin
            slot        = (int'(mirror_front) + k) % DEPTH;
            w.data      = ring_mirror[slot];
            w.occupancy = mirror_count;
            w.last      = (k == int'(mirror_count) - 1);
            expected_words.push_back(w);
         end
      end else begin
         case (mode)
            MODE_PUSH_FRONT, MODE_PUSH_BACK: begin
               if (int'(mirror_count) == DEPTH) begin
                  w.status = STATUS_OVER;
               end else begin
                  if (mode == MODE_PUSH_FRONT) begin
                     mirror_front = idx_type'((int'(mirror_front) + DEPTH - 1) % DEPTH);
                     slot = int'(mirror_front);
                  end else begin
                     slot = (int'(mirror_front) + int'(mirror_count)) % DEPTH;
                  end
                  ring_mirror[slot] = value;
                  mirror_count++;
               end
            end
            MODE_POP_FRONT, MODE_POP_BACK: begin
               if (mirror_count == 0) begin
                  w.status = STATUS_UNDER;
               end else begin
                  if (mode == MODE_POP_FRONT) begin
                     slot = int'(mirror_front);
                     mirror_front = idx_type'((int'(mirror_front) + 1) % DEPTH);
                  end else begin
                     slot = (int'(mirror_front) + int'(mirror_count) - 1) % DEPTH;
                  end
                  w.data = ring_mirror[slot];
                  mirror_count--;
               end
            end
            MODE_CLEAR: begin
               mirror_front = '0;
               mirror_count = '0;
            end
            MODE_CREATE: begin
               mirror_front   = '0;
               ring_mirror[0] = value;
               mirror_count   = occ_type'(1);
            end
            default: ;
         endcase
         w.occupancy = mirror_count;
         expected_words.push_back(w);
      end
   endtask

   // command driver
   always @(negedge clock) begin : drive_req
      deque_cmd_type c;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_taken) begin
         if (send_gap > 0) begin
            send_gap--;
            req_tvalid <= 1'b0;
         end else if (pending_cmds.size() != 0 &&
                      (!pending_cmds[0].hold || expected_words.size() == 0)) begin
            c = pending_cmds.pop_front();
            req_tvalid <= 1'b1;
            req_tdata  <= c.value;
            req_tuser  <= c.mode;
            send_gap = draw_gap(send_burst);
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // response backpressure
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_taken)
            recv_stall = draw_gap(recv_burst);
         if (recv_stall > 0) begin
            recv_stall--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // accept tracking, prediction and response checking
   always @(posedge clock) begin : watch
      rsp_type got;
      rsp_type want;
      cycle_count++;
      if (cycle_count > CYCLE_CAP) begin
         $display("bounded_double_ended_queue_core verification failed");
         $finish;
      end else if (!reset) begin
         req_taken <= req_tvalid && req_tready;
         rsp_taken <= rsp_tvalid && rsp_tready;
         if (req_tvalid && req_tready)
            deque_apply(req_tuser, req_tdata);
         if (rsp_tvalid && rsp_tready) begin
            got.data      = rsp_tdata[31:0];
            got.occupancy = rsp_tdata[38:32];
            got.status    = status_type'(rsp_tuser);
            got.last      = rsp_tlast;
            if (expected_words.size() == 0) begin
               mismatches++;
               if (mismatches <= SHOW_MAX)
                  $display("%0t: unexpected word data %h status %0d occupancy %0d last %0b",
                           $realtime, got.data, got.status, got.occupancy, got.last);
            end else begin
               want = expected_words.pop_front();
               if (got.data !== want.data || got.status !== want.status ||
                   got.occupancy !== want.occupancy || got.last !== want.last) begin
                  mismatches++;
                  if (mismatches <= SHOW_MAX) begin
                     $display("%0t: word mismatch, exp/got: data %h/%h status %0d/%0d",
                              $realtime, want.data, got.data, want.status, got.status);
                     $display("   occupancy %0d/%0d last %0b/%0b",
                              want.occupancy, got.occupancy, want.last, got.last);
                  end
               end
            end
         end
      end
   end

   initial begin : stimulus
      int kind;
      int n;
      int i;
      bit first;

      // empty deque corner cases
      queue_cmd(MODE_POP_FRONT, $urandom, 1'b0);
      queue_cmd(MODE_POP_BACK, $urandom, 1'b0);
      queue_cmd(MODE_DUMP, $urandom, 1'b0);
      queue_cmd(MODE_UNUSED, $urandom, 1'b0);
      queue_cmd(MODE_CLEAR, $urandom, 1'b0);
      // create, then push front wraps the front index below zero
      queue_cmd(MODE_CREATE, 32'h8000_0000, 1'b0);
      queue_cmd(MODE_PUSH_FRONT, 32'h7FFF_FFFF, 1'b0);
      queue_cmd(MODE_PUSH_BACK, 32'hFFFF_FFFF, 1'b0);
      queue_cmd(MODE_PUSH_FRONT, 32'h0000_0001, 1'b0);
      queue_cmd(MODE_PUSH_BACK, 32'h0000_0000, 1'b0);
      queue_cmd(MODE_DUMP, $urandom, 1'b0);
      queue_cmd(MODE_UNUSED, $urandom, 1'b0);
      queue_cmd(MODE_POP_FRONT, $urandom, 1'b0);
      queue_cmd(MODE_POP_BACK, $urandom, 1'b0);
      queue_cmd(MODE_DUMP, $urandom, 1'b0);
      queue_cmd(MODE_CLEAR, $urandom, 1'b0);
      queue_cmd(MODE_DUMP, $urandom, 1'b0);
      queue_cmd(MODE_PUSH_BACK, 32'hAAAA_AAAA, 1'b0);
      queue_cmd(MODE_PUSH_FRONT, 32'h5555_5555, 1'b0);
      queue_cmd(MODE_POP_BACK, $urandom, 1'b0);
      queue_cmd(MODE_POP_FRONT, $urandom, 1'b0);
      queue_cmd(MODE_POP_FRONT, $urandom, 1'b0);
      queue_cmd(MODE_CREATE, $urandom, 1'b0);

      // random part: opens with a fill to full and a full drain
      kind  = 0;
      first = 1'b1;
      while (cmds_queued < CMD_TARGET) begin
         case (kind)
            0: begin
               queue_cmd(MODE_DUMP, $urandom, 1'b1);
               while (plan_count < DEPTH)
                  queue_cmd($urandom_range(0, 1) ? MODE_PUSH_BACK : MODE_PUSH_FRONT,
                            rand_word(), 1'b0);
               n = $urandom_range(1, 3);
               for (i = 0; i < n; i++)
                  queue_cmd($urandom_range(0, 1) ? MODE_PUSH_BACK : MODE_PUSH_FRONT,
                            rand_word(), 1'b0);
               queue_cmd(MODE_DUMP, $urandom, 1'b0);
            end
            1: begin
               while (plan_count > 0)
                  queue_cmd($urandom_range(0, 1) ? MODE_POP_BACK : MODE_POP_FRONT,
                            $urandom, 1'b0);
               queue_cmd($urandom_range(0, 1) ? MODE_POP_BACK : MODE_POP_FRONT,
                         $urandom, 1'b0);
            end
            2: begin
               queue_cmd(MODE_CREATE, rand_word(), 1'b0);
               n = $urandom_range(0, 6);
               for (i = 0; i < n; i++)
                  queue_cmd($urandom_range(0, 1) ? MODE_PUSH_BACK : MODE_PUSH_FRONT,
                            rand_word(), 1'b0);
               queue_cmd(MODE_DUMP, $urandom, 1'b0);
            end
            3: begin
               queue_cmd($urandom_range(0, 1) ? MODE_CLEAR : MODE_DUMP, $urandom, 1'b0);
            end
            default: begin
               n = $urandom_range(4, 12);
               for (i = 0; i < n; i++) begin
                  case ($urandom_range(0, 19))
                     0, 1, 2:    queue_cmd(MODE_PUSH_FRONT, rand_word(), 1'b0);
                     3, 4, 5, 6: queue_cmd(MODE_PUSH_BACK, rand_word(), 1'b0);
                     7, 8, 9:    queue_cmd(MODE_POP_FRONT, $urandom, 1'b0);
                     10, 11, 12: queue_cmd(MODE_POP_BACK, $urandom, 1'b0);
                     13, 14:     queue_cmd(MODE_DUMP, $urandom, 1'b0);
                     15:         queue_cmd(MODE_CLEAR, $urandom, 1'b0);
                     16:         queue_cmd(MODE_CREATE, rand_word(), 1'b0);
                     17:         queue_cmd(MODE_UNUSED, $urandom, 1'b0);
                     default:    queue_cmd(MODE_PUSH_BACK, rand_word(), 1'b0);
                  endcase
               end
            end
         endcase
         if (first) begin
            kind  = 1;
            first = 1'b0;
         end else begin
            kind = ($urandom_range(0, 15) == 0) ? 0 : $urandom_range(1, 9);
         end
      end

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (pending_cmds.size() != 0 || req_tvalid)
         @(negedge clock);
      while (expected_words.size() != 0)
         @(negedge clock);
      repeat (TAIL_WAIT) @(negedge clock);

      if (mismatches == 0) begin
         $display("bounded_double_ended_queue_core verification clean");
      end else begin
         $display("bounded_double_ended_queue_core verification failed");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
rtl/bdq_pkg.sv
rtl/bdq_ram.sv
rtl/bdq_out.sv
rtl/bounded_double_ended_queue_core.sv
tb/tb.sv
